[rtl/mfhb_pkg.sv]
// Shared types, constants and microcode program for the MAC frame header builder.
// No dependencies; the register file, the top level, the checker and the testbench import it.
package mfhb_pkg;

  // transmit FIFO geometry
  localparam int FIFO_DEPTH = 128;
  localparam int CUR_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PC_W       = 5;

  // input operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_TXDONE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_TX_CMD  = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_FC_LOW     = 3'd0;
  localparam logic [2:0] REG_FC_HIGH    = 3'd1;
  localparam logic [2:0] REG_OWN_PAN    = 3'd2;
  localparam logic [2:0] REG_OWN_SHORT  = 3'd3;
  localparam logic [2:0] REG_OWN_LONG   = 3'd4;
  localparam logic [2:0] REG_DEST_PAN   = 3'd5;
  localparam logic [2:0] REG_DEST_ADDR  = 3'd6;

  // frame control fields and protocol constants
  localparam int         FC_ACK_BIT  = 5;
  localparam int         FC_PANC_BIT = 6;
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SHORT  = 2'd2;
  localparam logic [7:0] SEQ_RESET   = 8'h80;
  localparam logic [7:0] SEQ_MAX     = 8'hff;
  localparam logic [6:0] ADDR_HDRLEN = 7'd0;
  localparam logic [6:0] ADDR_FRMLEN = 7'd1;
  localparam logic [7:0] CMD_TX      = 8'h01;
  localparam logic [7:0] CMD_TX_ACK  = 8'h05;

  // configuration register file contents
  typedef struct packed {
    logic [7:0]  fc_low;
    logic [7:0]  fc_high;
    logic [15:0] own_pan;
    logic [15:0] own_short;
    logic [63:0] own_long;
    logic [15:0] dest_pan;
    logic [63:0] dest_addr;
  } cfg_regs_t;

  // byte source of one microcode step
  typedef enum logic [3:0] {
    SRC_NONE, SRC_FCL, SRC_FCH, SRC_SEQ, SRC_DPAN, SRC_DADDR, SRC_SPAN,
    SRC_SADDR, SRC_HDRLEN, SRC_FRMLEN, SRC_CMD, SRC_PAYLOAD, SRC_REFUSE
  } src_t;

  // branch condition taken after a step
  typedef enum logic [2:0] {
    JC_NEVER, JC_ALWAYS, JC_NO_DEST, JC_DM_SHORT, JC_NO_SPAN, JC_NO_SRC, JC_SM_SHORT
  } jcond_t;

  // end-of-request condition
  typedef enum logic [1:0] {
    DN_NEVER, DN_ALWAYS, DN_NOT_LAST
  } done_t;

  typedef struct packed {
    src_t            src;
    logic [2:0]      idx;
    jcond_t          jc;
    logic [PC_W-1:0] target;
    done_t           dn;
  } ucode_t;

  // program entry points and branch targets
  localparam logic [PC_W-1:0] PC_HDR    = 5'd0;
  localparam logic [PC_W-1:0] PC_SPAN   = 5'd13;
  localparam logic [PC_W-1:0] PC_SRC    = 5'd16;
  localparam logic [PC_W-1:0] PC_HLEN   = 5'd25;
  localparam logic [PC_W-1:0] PC_FLEN   = 5'd26;
  localparam logic [PC_W-1:0] PC_PAY    = 5'd28;
  localparam logic [PC_W-1:0] PC_REFUSE = 5'd29;

  function automatic ucode_t uw(src_t s, logic [2:0] i, jcond_t j,
                                logic [PC_W-1:0] t, done_t d);
    ucode_t w;
    w.src    = s;
    w.idx    = i;
    w.jc     = j;
    w.target = t;
    w.dn     = d;
    return w;
  endfunction

  // microcode ROM: one control word per step
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:  w = uw(SRC_FCL,     3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd1:  w = uw(SRC_FCH,     3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd2:  w = uw(SRC_SEQ,     3'd0, JC_NO_DEST,  PC_SPAN, DN_NEVER);
      5'd3:  w = uw(SRC_DPAN,    3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd4:  w = uw(SRC_DPAN,    3'd1, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd5:  w = uw(SRC_DADDR,   3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd6:  w = uw(SRC_DADDR,   3'd1, JC_DM_SHORT, PC_SPAN, DN_NEVER);
      5'd7:  w = uw(SRC_DADDR,   3'd2, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd8:  w = uw(SRC_DADDR,   3'd3, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd9:  w = uw(SRC_DADDR,   3'd4, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd10: w = uw(SRC_DADDR,   3'd5, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd11: w = uw(SRC_DADDR,   3'd6, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd12: w = uw(SRC_DADDR,   3'd7, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd13: w = uw(SRC_NONE,    3'd0, JC_NO_SPAN,  PC_SRC,  DN_NEVER);
      5'd14: w = uw(SRC_SPAN,    3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd15: w = uw(SRC_SPAN,    3'd1, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd16: w = uw(SRC_NONE,    3'd0, JC_NO_SRC,   PC_HLEN, DN_NEVER);
      5'd17: w = uw(SRC_SADDR,   3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd18: w = uw(SRC_SADDR,   3'd1, JC_SM_SHORT, PC_HLEN, DN_NEVER);
      5'd19: w = uw(SRC_SADDR,   3'd2, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd20: w = uw(SRC_SADDR,   3'd3, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd21: w = uw(SRC_SADDR,   3'd4, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd22: w = uw(SRC_SADDR,   3'd5, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd23: w = uw(SRC_SADDR,   3'd6, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd24: w = uw(SRC_SADDR,   3'd7, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd25: w = uw(SRC_HDRLEN,  3'd0, JC_NEVER,    PC_HDR,  DN_NOT_LAST);
      5'd26: w = uw(SRC_FRMLEN,  3'd0, JC_NEVER,    PC_HDR,  DN_NEVER);
      5'd27: w = uw(SRC_CMD,     3'd0, JC_NEVER,    PC_HDR,  DN_ALWAYS);
      5'd28: w = uw(SRC_PAYLOAD, 3'd0, JC_ALWAYS,   PC_FLEN, DN_NOT_LAST);
      5'd29: w = uw(SRC_REFUSE,  3'd0, JC_NEVER,    PC_HDR,  DN_ALWAYS);
      default: w = uw(SRC_NONE,  3'd0, JC_NEVER,    PC_HDR,  DN_ALWAYS);
    endcase
    return w;
  endfunction

  // pick byte idx of a 64-bit field, low byte first
  function automatic logic [7:0] byte_of(logic [63:0] v, logic [2:0] idx);
    return v[{idx, 3'b000} +: 8];
  endfunction

endpackage

[rtl/mfhb_in_if.sv]
// Input request channel of the frame header builder: valid/ready plus item fields.
// Stand-alone, no package dependency.
interface mfhb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, operation, data_byte, last, input ready);
  modport sink   (input valid, operation, data_byte, last, output ready);
endinterface

[rtl/mfhb_out_if.sv]
// Result channel of the frame header builder: valid/ready plus result fields.
// Stand-alone, no package dependency.
interface mfhb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] fifo_addr;
  logic [7:0] value;
  logic       overflow;
  logic       last_result;

  modport source (output valid, kind, fifo_addr, value, overflow, last_result,
                  input ready);
  modport sink   (input valid, kind, fifo_addr, value, overflow, last_result,
                  output ready);
endinterface

[rtl/mfhb_cfg_if.sv]
// Configuration write channel: valid/ready, register index and write data.
// Stand-alone, no package dependency.
interface mfhb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mfhb_cfg_regs.sv]
// Configuration register file of the frame header builder.
// Depends on mfhb_pkg and mfhb_cfg_if.
module mfhb_cfg_regs
  import mfhb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  mfhb_cfg_if.sink      cfg_ch,
  output cfg_regs_t     regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  // register decode, unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FC_LOW:    regs_nxt.fc_low    = cfg_ch.data[7:0];
        REG_FC_HIGH:   regs_nxt.fc_high   = cfg_ch.data[7:0];
        REG_OWN_PAN:   regs_nxt.own_pan   = cfg_ch.data[15:0];
        REG_OWN_SHORT: regs_nxt.own_short = cfg_ch.data[15:0];
        REG_OWN_LONG:  regs_nxt.own_long  = cfg_ch.data;
        REG_DEST_PAN:  regs_nxt.dest_pan  = cfg_ch.data[15:0];
        REG_DEST_ADDR: regs_nxt.dest_addr = cfg_ch.data;
        default:       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

[rtl/mac_frame_header_builder.sv]
// Top level of the 802.15.4 MAC frame header builder: microcoded sequencer and datapath.
// Depends on mfhb_pkg, the three channel interfaces and mfhb_cfg_regs.
//
// Turns start, payload-byte and transmission-finished requests into a stream of
// transmit FIFO writes, start commands and refusals. An accepted request is
// registered on entry, then the microcode steps run; a step with a result waits
// while the result register holds one not yet taken. A payload byte gives one
// write, a closing one also the frame length and start command, a refused start
// one refusal, a frame start up to 24 writes plus two skip steps by address mode,
// and the length and command too when it closes an empty frame. The step counter
// walks the control ROM; the input is not taken while a program runs. The result
// register lets the next request enter while the last result still waits.
// Writes beyond the FIFO depth are reported with overflow set and dropped.
module mac_frame_header_builder
  import mfhb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mfhb_in_if.sink    in_ch,
  mfhb_out_if.source out_ch,
  mfhb_cfg_if.sink   cfg_ch
);

  cfg_regs_t regs;

  mfhb_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  // control state
  logic             run_r, run_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic             busy_r, busy_nxt;
  logic             collecting_r, collecting_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request payload and result payload
  logic       last_r, last_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] value_r, value_nxt;
  logic       ovf_r, ovf_nxt;
  logic       lres_r, lres_nxt;

  ucode_t      uc;
  logic [1:0]  dm;
  logic [1:0]  sm;
  logic        emit;
  logic        fire;
  logic        done;
  logic        jump;
  logic        in_acc;
  logic        fifo_src;
  logic [7:0]  src_byte;
  logic [15:0] cur_ext;
  logic [7:0]  len;
  logic [63:0] saddr;

  assign in_ch.ready        = !run_r;
  assign in_acc             = in_ch.valid && !run_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.fifo_addr   = addr_r;
  assign out_ch.value       = value_r;
  assign out_ch.overflow    = ovf_r;
  assign out_ch.last_result = lres_r;

  // control word and frame control decode
  assign uc    = ucode_rom(pc_r);
  assign dm    = regs.fc_high[3:2];
  assign sm    = regs.fc_high[7:6];
  assign emit  = (uc.src != SRC_NONE);
  assign fire  = run_r && (!emit || !out_valid_r || out_ch.ready);
  assign saddr = sm[0] ? regs.own_long : {48'd0, regs.own_short};

  // length of kept bytes after the two length slots, modulo 256
  assign cur_ext = 16'(cursor_r);
  assign len     = 8'(cur_ext - 16'd2);

  // end of request and branch decision
  always_comb begin
    unique case (uc.dn)
      DN_NEVER:    done = 1'b0;
      DN_ALWAYS:   done = 1'b1;
      DN_NOT_LAST: done = !last_r;
      default:     done = 1'b1;
    endcase
    unique case (uc.jc)
      JC_NEVER:    jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_NO_DEST:  jump = !dm[1];
      JC_DM_SHORT: jump = (dm == MODE_SHORT);
      JC_NO_SPAN:  jump = !((dm != MODE_NONE) && (sm != MODE_NONE)
                            && !regs.fc_low[FC_PANC_BIT]);
      JC_NO_SRC:   jump = !sm[1];
      JC_SM_SHORT: jump = (sm == MODE_SHORT);
      default:     jump = 1'b0;
    endcase
  end

  // byte source mux
  always_comb begin
    fifo_src = 1'b1;
    unique case (uc.src)
      SRC_FCL:     src_byte = regs.fc_low;
      SRC_FCH:     src_byte = regs.fc_high;
      SRC_SEQ:     src_byte = seq_r;
      SRC_DPAN:    src_byte = byte_of({48'd0, regs.dest_pan}, uc.idx);
      SRC_DADDR:   src_byte = byte_of(regs.dest_addr, uc.idx);
      SRC_SPAN:    src_byte = byte_of({48'd0, regs.own_pan}, uc.idx);
      SRC_SADDR:   src_byte = byte_of(saddr, uc.idx);
      SRC_PAYLOAD: src_byte = byte_r;
      default: begin
        src_byte = len;
        fifo_src = 1'b0;
      end
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    run_nxt        = run_r;
    pc_nxt         = pc_r;
    busy_nxt       = busy_r;
    collecting_nxt = collecting_r;
    seq_nxt        = seq_r;
    cursor_nxt     = cursor_r;
    out_valid_nxt  = out_valid_r;
    last_nxt       = last_r;
    byte_nxt       = byte_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    value_nxt      = value_r;
    ovf_nxt        = ovf_r;
    lres_nxt       = lres_r;

    // result register drains
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // request entry picks the program; a finished transmission only clears busy
    if (in_acc) begin
      last_nxt = in_ch.last;
      byte_nxt = in_ch.data_byte;
      unique case (in_ch.operation)
        OP_START: begin
          run_nxt = 1'b1;
          if (busy_r || collecting_r) begin
            pc_nxt = PC_REFUSE;
          end else begin
            pc_nxt     = PC_HDR;
            cursor_nxt = CUR_W'(2);
          end
        end
        OP_BYTE: begin
          if (collecting_r) begin
            run_nxt = 1'b1;
            pc_nxt  = PC_PAY;
          end
        end
        OP_TXDONE: busy_nxt = 1'b0;
        default:   run_nxt = run_r;
      endcase
    end

    // one microcode step
    if (fire) begin
      if (done) begin
        run_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = uc.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end

      if (emit) begin
        out_valid_nxt = 1'b1;
        lres_nxt      = done;
        kind_nxt      = KIND_WRITE;
        addr_nxt      = '0;
        value_nxt     = src_byte;
        ovf_nxt       = 1'b0;
        if (fifo_src) begin
          if (cursor_r < CUR_W'(FIFO_DEPTH)) begin
            addr_nxt   = cursor_r[6:0];
            cursor_nxt = cursor_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        unique case (uc.src)
          SRC_SEQ: begin
            seq_nxt = (seq_r == SEQ_MAX) ? SEQ_RESET : seq_r + 8'd1;
          end
          SRC_HDRLEN: begin
            addr_nxt       = ADDR_HDRLEN;
            collecting_nxt = 1'b1;
          end
          SRC_FRMLEN: addr_nxt = ADDR_FRMLEN;
          SRC_CMD: begin
            kind_nxt       = KIND_TX_CMD;
            value_nxt      = regs.fc_low[FC_ACK_BIT] ? CMD_TX_ACK : CMD_TX;
            collecting_nxt = 1'b0;
            busy_nxt       = 1'b1;
          end
          SRC_REFUSE: begin
            kind_nxt  = KIND_REFUSED;
            value_nxt = '0;
          end
          default: seq_nxt = seq_r;
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      pc_r         <= PC_HDR;
      busy_r       <= 1'b0;
      collecting_r <= 1'b0;
      seq_r        <= SEQ_RESET;
      cursor_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      run_r        <= run_nxt;
      pc_r         <= pc_nxt;
      busy_r       <= busy_nxt;
      collecting_r <= collecting_nxt;
      seq_r        <= seq_nxt;
      cursor_r     <= cursor_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    byte_r  <= byte_nxt;
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
    ovf_r   <= ovf_nxt;
    lres_r  <= lres_nxt;
  end

endmodule

[rtl/mfhb_checker.sv]
// Port-level checks on the frame header builder and the bind that attaches them.
// Depends on mfhb_pkg and mac_frame_header_builder.
module mfhb_checker
  import mfhb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [6:0] fifo_addr,
  input logic [7:0] value,
  input logic       overflow,
  input logic       last_result
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({kind, fifo_addr, value,
                                                      overflow, last_result}))
    else $error("result changed while stalled");

  // a refusal closes its request and carries value zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_REFUSED |-> last_result && value == 8'd0)
    else $error("refusal not final or nonzero");

  // the start command closes the request and carries a valid command
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_TX_CMD |->
      last_result && (value == CMD_TX || value == CMD_TX_ACK))
    else $error("bad start command");

  // a dropped write reports address zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> kind == KIND_WRITE && fifo_addr == 7'd0)
    else $error("bad overflow report");

endmodule

bind mac_frame_header_builder mfhb_checker u_mfhb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .fifo_addr   (out_ch.fifo_addr),
  .value       (out_ch.value),
  .overflow    (out_ch.overflow),
  .last_result (out_ch.last_result)
);

[tb/tb_mac_frame_header_builder.sv]
// Self-checking testbench for mac_frame_header_builder: directed and random requests.
// Depends on mfhb_pkg, the three channel interfaces and the block itself.
// A local model of the FIFO writes is checked against every result.
module tb_mac_frame_header_builder;
  import mfhb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [1:0] MODE_RESERVED = 2'd1;
  localparam logic [1:0] MODE_LONG     = 2'd3;

  localparam int IDLE_PCT      = 28;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES  = 150;

  // one expected entry of the result stream
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] fifo_addr;
    logic [7:0] value;
    logic       overflow;
    logic       last_result;
  } fifo_write_t;

  logic clk;
  logic rst_n;

  mfhb_in_if  in_ch ();
  mfhb_out_if out_ch ();
  mfhb_cfg_if cfg_ch ();

  mac_frame_header_builder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // model state, mirrors the block after reset
  cfg_regs_t   regs          = '0;
  logic        tx_busy       = 1'b0;
  logic        collecting    = 1'b0;
  logic [7:0]  seq_num       = SEQ_RESET;
  int          cursor        = 0;

  fifo_write_t expected_writes[$];
  int          mismatch_count = 0;
  int          requests_sent  = 0;
  int          idle_pct       = IDLE_PCT;
  int          stall_left     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit: ~230 requests, each a microcode program plus its results
  // under receiver stalls, stays well below this
  initial begin
    #3ms;
    $display("tb_mac_frame_header_builder failed");
    $finish;
  end

  // ---------------- model of the header builder ----------------

  function automatic logic [7:0] fc_high_of(logic [1:0] dm, logic [1:0] sm);
    return {sm, 2'b00, dm, 2'b00};
  endfunction

  function automatic void push_write(logic [1:0] k, logic [6:0] a, logic [7:0] v,
                                     logic ovf);
    fifo_write_t w;
    w = '{kind: k, fifo_addr: a, value: v, overflow: ovf, last_result: 1'b0};
    expected_writes.push_back(w);
  endfunction

  // one byte into the FIFO, dropped once the cursor hits the end
  function automatic void fifo_put(logic [7:0] b);
    if (cursor < FIFO_DEPTH) begin
      push_write(KIND_WRITE, 7'(cursor), b, 1'b0);
      cursor++;
    end else begin
      push_write(KIND_WRITE, 7'd0, b, 1'b1);
    end
  endfunction

  // multi-byte field, low byte first
  function automatic void fifo_put_field(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) fifo_put(v[8*i +: 8]);
  endfunction

  function automatic void close_frame();
    logic ack;
    ack = regs.fc_low[FC_ACK_BIT];
    push_write(KIND_WRITE, ADDR_FRMLEN, 8'(cursor - 2), 1'b0);
    push_write(KIND_TX_CMD, 7'd0, ack ? CMD_TX_ACK : CMD_TX, 1'b0);
    collecting = 1'b0;
    tx_busy    = 1'b1;
  endfunction

  // expected FIFO writes for one accepted request
  function automatic void predict_fifo_writes(logic [1:0] op, logic [7:0] b, logic lst);
    int          n0;
    logic [1:0]  dm;
    logic [1:0]  sm;
    fifo_write_t tail;
    n0 = expected_writes.size();
    case (op)
      OP_START: begin
        if (tx_busy || collecting) begin
          push_write(KIND_REFUSED, 7'd0, 8'd0, 1'b0);
        end else begin
          dm     = regs.fc_high[3:2];
          sm     = regs.fc_high[7:6];
          cursor = 2;
          fifo_put(regs.fc_low);
          fifo_put(regs.fc_high);
          fifo_put(seq_num);
          seq_num = (seq_num == SEQ_MAX) ? SEQ_RESET : seq_num + 8'd1;
          if (dm == MODE_SHORT || dm == MODE_LONG) begin
            fifo_put_field(64'(regs.dest_pan), 2);
            fifo_put_field(regs.dest_addr, (dm == MODE_SHORT) ? 2 : 8);
          end
          // source pan only with both ends present and no compression
          if (dm != MODE_NONE && sm != MODE_NONE && !regs.fc_low[FC_PANC_BIT])
            fifo_put_field(64'(regs.own_pan), 2);
          if (sm == MODE_SHORT) fifo_put_field(64'(regs.own_short), 2);
          else if (sm == MODE_LONG) fifo_put_field(regs.own_long, 8);
          push_write(KIND_WRITE, ADDR_HDRLEN, 8'(cursor - 2), 1'b0);
          collecting = 1'b1;
          if (lst) close_frame();
        end
      end
      OP_BYTE: begin
        if (collecting) begin
          fifo_put(b);
          if (lst) close_frame();
        end
      end
      OP_TXDONE: tx_busy = 1'b0;
      default: ;
    endcase
    if (expected_writes.size() > n0) begin
      tail = expected_writes.pop_back();
      tail.last_result = 1'b1;
      expected_writes.push_back(tail);
    end
  endfunction

  // ---------------- channel drivers ----------------

  // one request on the input channel, random idle before it
  task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    in_ch.last      <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    requests_sent++;
    predict_fifo_writes(op, b, lst);
  endtask

  // drop valid, let every expected write arrive, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_FC_LOW:    regs.fc_low    = d[7:0];
      REG_FC_HIGH:   regs.fc_high   = d[7:0];
      REG_OWN_PAN:   regs.own_pan   = d[15:0];
      REG_OWN_SHORT: regs.own_short = d[15:0];
      REG_OWN_LONG:  regs.own_long  = d;
      REG_DEST_PAN:  regs.dest_pan  = d[15:0];
      REG_DEST_ADDR: regs.dest_addr = d;
      default: ;
    endcase
  endtask

  // full register set, written only once the block is idle
  task automatic apply_config(input cfg_regs_t c);
    wait_idle();
    write_reg(REG_FC_LOW,    64'(c.fc_low));
    write_reg(REG_FC_HIGH,   64'(c.fc_high));
    write_reg(REG_OWN_PAN,   64'(c.own_pan));
    write_reg(REG_OWN_SHORT, 64'(c.own_short));
    write_reg(REG_OWN_LONG,  c.own_long);
    write_reg(REG_DEST_PAN,  64'(c.dest_pan));
    write_reg(REG_DEST_ADDR, c.dest_addr);
    cfg_ch.valid <= 1'b0;
  endtask

  // result receiver: random stalls plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // result checker against the oldest expected write
  always @(posedge clk) begin
    fifo_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected result: kind %0d addr %0d value 0x%02h", out_ch.kind,
               out_ch.fifo_addr, out_ch.value);
        mismatch_count++;
      end else begin
        want = expected_writes.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          mismatch_count++;
        end
        if (out_ch.fifo_addr !== want.fifo_addr) begin
          $error("fifo_addr: expected %0d, got %0d", want.fifo_addr, out_ch.fifo_addr);
          mismatch_count++;
        end
        if (out_ch.value !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, out_ch.value);
          mismatch_count++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
          mismatch_count++;
        end
        if (out_ch.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result,
                 out_ch.last_result);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  // reset settings: header only, refused start while busy, stray byte
  task automatic test_empty_frame_defaults();
    send_request(OP_START, 8'hff, 1'b1);
    send_request(OP_START, 8'h00, 1'b0);
    send_request(OP_BYTE, 8'hff, 1'b0);
    send_request(OP_TXDONE, 8'h00, 1'b0);
  endtask

  // every register at its maximum: long addresses, compression, ack command
  task automatic test_all_ones();
    cfg_regs_t c;
    c = '{fc_low: 8'hff, fc_high: 8'hff, own_pan: '1, own_short: '1, own_long: '1,
          dest_pan: '1, dest_addr: '1};
    apply_config(c);
    send_request(OP_START, 8'h00, 1'b0);
    send_request(OP_BYTE, 8'h00, 1'b0);
    send_request(OP_START, 8'hff, 1'b1);
    send_request(OP_BYTE, 8'hff, 1'b1);
    send_request(OP_TXDONE, 8'hff, 1'b1);
  endtask

  // short addresses with source pan; finished and unused ops mid frame
  task automatic test_short_addressing();
    cfg_regs_t c;
    c = '{fc_low: 8'h01, fc_high: fc_high_of(MODE_SHORT, MODE_SHORT),
          own_pan: 16'h1234, own_short: 16'hbeef, own_long: 64'h0123456789abcdef,
          dest_pan: 16'h00ff, dest_addr: 64'hfedcba9876543210};
    apply_config(c);
    send_request(OP_START, 8'h00, 1'b0);
    send_request(OP_TXDONE, 8'h00, 1'b0);
    send_request(OP_UNUSED, 8'h5a, 1'b1);
    send_request(OP_BYTE, 8'h5a, 1'b1);
    send_request(OP_TXDONE, 8'h00, 1'b0);
  endtask

  // reserved mode counts as present for the source pan but writes no address; one-sided address modes
  task automatic test_reserved_modes();
    cfg_regs_t  c;
    logic [7:0] fcl [4];
    logic [7:0] fch [4];
    fcl[0] = 8'h20;  fch[0] = fc_high_of(MODE_RESERVED, MODE_LONG);
    fcl[1] = 8'h00;  fch[1] = fc_high_of(MODE_LONG, MODE_RESERVED);
    fcl[2] = 8'h40;  fch[2] = fc_high_of(MODE_NONE, MODE_SHORT);
    fcl[3] = 8'h00;  fch[3] = fc_high_of(MODE_SHORT, MODE_NONE);
    for (int i = 0; i < 4; i++) begin
      c = '{fc_low: fcl[i], fc_high: fch[i], own_pan: 16'($urandom),
            own_short: 16'($urandom), own_long: {$urandom, $urandom},
            dest_pan: 16'($urandom), dest_addr: {$urandom, $urandom}};
      apply_config(c);
      send_request(OP_START, 8'($urandom), 1'b1);
      send_request(OP_TXDONE, 8'($urandom), 1'b0);
    end
  endtask

  // empty frames back to back, with no idling on either side
  task automatic test_back_to_back();
    cfg_regs_t c;
    c = '{fc_low: 8'h00, fc_high: fc_high_of(MODE_NONE, MODE_NONE), own_pan: '0,
          own_short: '0, own_long: '0, dest_pan: '0, dest_addr: '0};
    apply_config(c);
    idle_pct = 0;
    repeat (20) begin
      send_request(OP_START, 8'($urandom), 1'b1);
      send_request(OP_TXDONE, 8'($urandom), 1'b0);
    end
    idle_pct = IDLE_PCT;
  endtask

  // longest header plus payload past the FIFO end, receiver held off
  task automatic test_fifo_overflow();
    cfg_regs_t c;
    c = '{fc_low: 8'h20, fc_high: fc_high_of(MODE_LONG, MODE_LONG),
          own_pan: 16'($urandom), own_short: 16'($urandom),
          own_long: {$urandom, $urandom}, dest_pan: 16'($urandom),
          dest_addr: {$urandom, $urandom}};
    apply_config(c);
    stall_left = STALL_CYCLES;
    send_request(OP_START, 8'($urandom), 1'b0);
    for (int i = 0; i < 106; i++) send_request(OP_BYTE, 8'($urandom), i == 105);
    send_request(OP_TXDONE, 8'($urandom), 1'b0);
  endtask

  // random settings per phase; mostly well-formed frames, some noise
  task automatic test_random_traffic();
    cfg_regs_t c;
    int        stop_at;
    int        plen;
    int        r;
    logic [1:0] noise_op [3];
    noise_op[0] = OP_START;
    noise_op[1] = OP_TXDONE;
    noise_op[2] = OP_UNUSED;
    repeat (3) begin
      c = '{fc_low: 8'($urandom), fc_high: 8'($urandom), own_pan: 16'($urandom),
            own_short: 16'($urandom), own_long: {$urandom, $urandom},
            dest_pan: 16'($urandom), dest_addr: {$urandom, $urandom}};
      apply_config(c);
      stop_at = requests_sent + 14;
      while (requests_sent < stop_at) begin
        if ($urandom_range(99) < 12) begin
          // lone request of any operation
          send_request(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
        end else begin
          r    = $urandom_range(99);
          plen = (r < 25) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
          send_request(OP_START, 8'($urandom), plen == 0);
          for (int i = 0; i < plen; i++) begin
            if ($urandom_range(99) < 8)
              send_request(noise_op[$urandom_range(2)], 8'($urandom), 1'($urandom));
            send_request(OP_BYTE, 8'($urandom), i == plen - 1);
          end
          // start while busy, and now and then no finish at all
          if ($urandom_range(99) < 15)
            send_request(OP_START, 8'($urandom), 1'($urandom));
          if ($urandom_range(99) < 85)
            send_request(OP_TXDONE, 8'($urandom), 1'($urandom));
        end
      end
      // close any open frame before the settings change
      if (collecting) send_request(OP_BYTE, 8'($urandom), 1'b1);
      send_request(OP_TXDONE, 8'($urandom), 1'b0);
    end
  endtask

  // ---------------- main sequence ----------------

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_START;
    in_ch.data_byte = 8'd0;
    in_ch.last      = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_FC_LOW;
    cfg_ch.data     = 64'd0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_frame_defaults();
    test_all_ones();
    test_short_addressing();
    test_reserved_modes();
    test_back_to_back();
    test_fifo_overflow();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_mac_frame_header_builder passed");
    end else begin
      $display("tb_mac_frame_header_builder failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mfhb_pkg.sv
rtl/mfhb_in_if.sv
rtl/mfhb_out_if.sv
rtl/mfhb_cfg_if.sv
rtl/mfhb_cfg_regs.sv
rtl/mac_frame_header_builder.sv
rtl/mfhb_checker.sv
tb/tb_mac_frame_header_builder.sv
